@@ src/ptrm_pkg.sv @@
package ptrm_pkg;

	localparam int MODE_W    = 2;
	localparam int TS_W      = 48;
	localparam int CNT_W     = 32;
	localparam int RATE_W    = 24;
	localparam int WINCFG_W  = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;
	localparam int DIV_CNT_W = 5;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(RATE_W - 1);

	localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_STOP   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_COUNTER_FREQ = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD  = 2'd2;

	localparam logic [CNT_W-1:0]    RST_COUNTER_FREQ = 32'd10000000;
	localparam logic [WINCFG_W-1:0] RST_WINDOW_LEN   = 7'd60;
	localparam logic [CNT_W-1:0]    RST_TICK_PERIOD  = 32'd166667;

	localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
	localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL,
		ST_UPDATE,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic clear_step;
		logic latch;
		logic eval;
		logic update;
		logic prep;
		logic div_step;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic is_tick;
		logic div_last;
	} dp_status_t;

endpackage

@@ src/ptrm_if.sv @@
interface ptrm_item_if;
	logic                              valid;
	logic                              ready;
	logic [ptrm_pkg::MODE_W-1:0]       mode;
	logic [ptrm_pkg::TS_W-1:0]         timestamp;

	modport source (output valid, output mode, output timestamp, input ready);
	modport sink (input valid, input mode, input timestamp, output ready);
endinterface

interface ptrm_result_if;
	logic                              valid;
	logic                              ready;
	logic [ptrm_pkg::CNT_W-1:0]        elapsed_counts;
	logic [ptrm_pkg::RATE_W-1:0]       rate_q8;
	logic                              rate_saturated;

	modport source (output valid, output elapsed_counts, output rate_q8,
		output rate_saturated, input ready);
	modport sink (input valid, input elapsed_counts, input rate_q8,
		input rate_saturated, output ready);
endinterface

interface ptrm_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [ptrm_pkg::CFG_IDX_W-1:0]    index;
	logic [ptrm_pkg::CFG_DAT_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/ptrm_ctrl.sv @@
module ptrm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ptrm_pkg::dp_cmd_t    cmd,
	input  ptrm_pkg::dp_status_t status
);

	ptrm_pkg::ctrl_state_t state_q, state_d;
	logic                  out_valid_q;
	logic                  out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptrm_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptrm_pkg::ST_CLEAR: begin
				if (status.clear_last) begin
					state_d = ptrm_pkg::ST_IDLE;
				end
			end
			ptrm_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = ptrm_pkg::ST_EVAL;
				end
			end
			ptrm_pkg::ST_EVAL: begin
				state_d = status.is_tick ? ptrm_pkg::ST_UPDATE : ptrm_pkg::ST_IDLE;
			end
			ptrm_pkg::ST_UPDATE: state_d = ptrm_pkg::ST_PREP;
			ptrm_pkg::ST_PREP:   state_d = ptrm_pkg::ST_DIV;
			ptrm_pkg::ST_DIV: begin
				if (status.div_last) begin
					state_d = ptrm_pkg::ST_DONE;
				end
			end
			ptrm_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = ptrm_pkg::ST_IDLE;
				end
			end
			default: state_d = ptrm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = (state_q == ptrm_pkg::ST_IDLE);
		cmd            = '0;
		cmd.clear_step = (state_q == ptrm_pkg::ST_CLEAR);
		cmd.latch      = (state_q == ptrm_pkg::ST_IDLE) && in_valid;
		cmd.eval       = (state_q == ptrm_pkg::ST_EVAL);
		cmd.update     = (state_q == ptrm_pkg::ST_UPDATE);
		cmd.prep       = (state_q == ptrm_pkg::ST_PREP);
		cmd.div_step   = (state_q == ptrm_pkg::ST_DIV);
		cmd.load_out   = (state_q == ptrm_pkg::ST_DONE) && out_free;
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptrm_pkg::ST_CLEAR) |-> !in_ready)
		else $error("item accepted during ring clear");

	a_prep_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptrm_pkg::ST_UPDATE) |=> (state_q == ptrm_pkg::ST_PREP) ##1
		(state_q == ptrm_pkg::ST_DIV))
		else $error("tick sequence broken");

endmodule

@@ src/ptrm_dp.sv @@
module ptrm_dp #(
	parameter int WINDOW = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ptrm_pkg::dp_cmd_t                  cmd,
	output ptrm_pkg::dp_status_t               status,
	input  logic [ptrm_pkg::MODE_W-1:0]        in_mode,
	input  logic [ptrm_pkg::TS_W-1:0]          in_timestamp,
	input  logic                               cfg_we,
	input  logic [ptrm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ptrm_pkg::CFG_DAT_W-1:0]     cfg_data,
	output logic [ptrm_pkg::CNT_W-1:0]         elapsed_counts,
	output logic [ptrm_pkg::RATE_W-1:0]        rate_q8,
	output logic                               rate_saturated
);

	localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int WIN_W  = $clog2(WINDOW + 1);
	localparam int CMP_W  = (WIN_W > ptrm_pkg::WINCFG_W) ? WIN_W : ptrm_pkg::WINCFG_W;
	localparam int SUM_W  = ptrm_pkg::CNT_W + $clog2(WINDOW);
	localparam int PROD_W = ptrm_pkg::CNT_W + WIN_W;
	localparam int NUM_W  = PROD_W + 8;
	localparam int SATC_W = SUM_W + ptrm_pkg::RATE_W;

	logic [ptrm_pkg::CNT_W-1:0]    counter_freq_q;
	logic [ptrm_pkg::WINCFG_W-1:0] window_len_q;
	logic [ptrm_pkg::CNT_W-1:0]    tick_period_q;

	logic [ptrm_pkg::MODE_W-1:0]   mode_q;
	logic [ptrm_pkg::TS_W-1:0]     ts_q;
	logic                          running_q;
	logic [ptrm_pkg::TS_W-1:0]     last_tick_q;
	logic [SUM_W-1:0]              sum_q;
	logic [IDX_W-1:0]              ring_idx_q;
	logic [IDX_W-1:0]              clr_addr_q;
	logic [IDX_W-1:0]              slot_q;
	logic [ptrm_pkg::CNT_W-1:0]    interval_q;
	logic [ptrm_pkg::CNT_W-1:0]    rd_q;
	logic [PROD_W-1:0]             prod_q;
	logic [SUM_W-1:0]              rem_q;
	logic [ptrm_pkg::RATE_W-1:0]   low_q;
	logic [ptrm_pkg::RATE_W-1:0]   quo_q;
	logic [ptrm_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic                          zero_q;
	logic                          sat_q;

	logic [ptrm_pkg::CNT_W-1:0]    ring_mem [WINDOW];

	logic [ptrm_pkg::TS_W-1:0]     elapsed;
	logic [ptrm_pkg::CNT_W-1:0]    elapsed_sat;
	logic [WIN_W-1:0]              win;
	logic [IDX_W-1:0]              slot;
	logic [WIN_W-1:0]              slot_inc;
	logic [IDX_W-1:0]              idx_next;
	logic [NUM_W-1:0]              num;
	logic [SUM_W:0]                trial;
	logic                          trial_ge;

	always_comb begin
		elapsed     = ts_q - last_tick_q;
		elapsed_sat = (elapsed[ptrm_pkg::TS_W-1:ptrm_pkg::CNT_W] != '0) ?
			ptrm_pkg::CNT_MAX : elapsed[ptrm_pkg::CNT_W-1:0];

		if (window_len_q == '0) begin
			win = WIN_W'(1);
		end else if (CMP_W'(window_len_q) > CMP_W'(WINDOW)) begin
			win = WIN_W'(WINDOW);
		end else begin
			win = WIN_W'(window_len_q);
		end

		slot     = (WIN_W'(ring_idx_q) < win) ? ring_idx_q : '0;
		slot_inc = WIN_W'(slot_q) + WIN_W'(1);
		idx_next = (slot_inc < win) ? slot_inc[IDX_W-1:0] : '0;

		num      = {prod_q, 8'b0};
		trial    = {rem_q, low_q[ptrm_pkg::RATE_W-1]};
		trial_ge = (trial >= {1'b0, sum_q});

		status.is_tick    = running_q && (mode_q == ptrm_pkg::MODE_SAMPLE) &&
			(elapsed >= ptrm_pkg::TS_W'(tick_period_q));
		status.clear_last = (clr_addr_q == IDX_W'(WINDOW - 1));
		status.div_last   = (div_cnt_q == ptrm_pkg::DIV_LAST_STEP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_freq_q <= ptrm_pkg::RST_COUNTER_FREQ;
			window_len_q   <= ptrm_pkg::RST_WINDOW_LEN;
			tick_period_q  <= ptrm_pkg::RST_TICK_PERIOD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptrm_pkg::REG_COUNTER_FREQ: counter_freq_q <= cfg_data;
				ptrm_pkg::REG_WINDOW_LEN:   window_len_q <= cfg_data[ptrm_pkg::WINCFG_W-1:0];
				ptrm_pkg::REG_TICK_PERIOD:  tick_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			last_tick_q <= '0;
			sum_q       <= '0;
			ring_idx_q  <= '0;
			clr_addr_q  <= '0;
			div_cnt_q   <= '0;
		end else begin
			if (cmd.clear_step) begin
				clr_addr_q <= clr_addr_q + IDX_W'(1);
			end
			if (cmd.eval) begin
				if (mode_q == ptrm_pkg::MODE_START) begin
					running_q   <= 1'b1;
					last_tick_q <= ts_q;
				end else if (mode_q == ptrm_pkg::MODE_STOP) begin
					running_q <= 1'b0;
				end else if (status.is_tick) begin
					last_tick_q <= ts_q;
				end
			end
			if (cmd.update) begin
				sum_q      <= sum_q - SUM_W'(rd_q) + SUM_W'(interval_q);
				ring_idx_q <= idx_next;
			end
			if (cmd.prep) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + ptrm_pkg::DIV_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			ring_mem[clr_addr_q] <= '0;
		end else if (cmd.update) begin
			ring_mem[slot_q] <= interval_q;
		end
		if (cmd.eval) begin
			rd_q <= ring_mem[slot];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q <= in_mode;
			ts_q   <= in_timestamp;
		end
		if (cmd.eval) begin
			interval_q <= elapsed_sat;
			slot_q     <= slot;
		end
		if (cmd.update) begin
			prod_q <= PROD_W'(win) * PROD_W'(counter_freq_q);
		end
		if (cmd.prep) begin
			zero_q <= (sum_q == '0);
			sat_q  <= (sum_q == '0) || (SATC_W'(num) >= {sum_q, {ptrm_pkg::RATE_W{1'b0}}});
			rem_q  <= SUM_W'(num[NUM_W-1:ptrm_pkg::RATE_W]);
			low_q  <= num[ptrm_pkg::RATE_W-1:0];
			quo_q  <= '0;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? SUM_W'(trial - {1'b0, sum_q}) : trial[SUM_W-1:0];
			low_q <= {low_q[ptrm_pkg::RATE_W-2:0], 1'b0};
			quo_q <= {quo_q[ptrm_pkg::RATE_W-2:0], trial_ge};
		end
		if (cmd.load_out) begin
			elapsed_counts <= interval_q;
			rate_q8        <= sat_q ? ptrm_pkg::RATE_MAX : quo_q;
			rate_saturated <= sat_q;
		end
	end

	a_zero_sum_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out && zero_q |-> sat_q)
		else $error("zero interval sum without saturation");

endmodule

@@ src/periodic_tick_rate_monitor_top.sv @@
// Tick rate monitor: items on the item channel are start, sample or stop
// commands carrying a 48-bit counter timestamp. A sample taken while running
// that is at least tick_period counts past the last tick yields one result
// with the interval (saturated to 32 bits) and the average rate
// window*counter_freq/sum of the last window intervals in Q16.8, clipped to
// 24 bits. Commands and non-tick samples pass through the evaluate state
// back to idle; a tick goes on through update, prep and the one-bit-per-cycle
// restoring divider before its result is loaded. A finished result waits in
// the output register while the next item is taken. After reset the interval
// ring is cleared one slot per cycle, and no item is taken until it is clear.
// Configuration writes are always taken and can act on an item in progress.
module periodic_tick_rate_monitor_top #(
	parameter int WINDOW = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ptrm_item_if.sink            item,
	ptrm_result_if.source        result,
	ptrm_cfg_if.sink             cfg
);

	ptrm_pkg::dp_cmd_t    cmd;
	ptrm_pkg::dp_status_t status;

	assign cfg.ready = 1'b1;

	ptrm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.status    (status)
	);

	ptrm_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.in_mode        (item.mode),
		.in_timestamp   (item.timestamp),
		.cfg_we         (cfg.valid && cfg.ready),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.elapsed_counts (result.elapsed_counts),
		.rate_q8        (result.rate_q8),
		.rate_saturated (result.rate_saturated)
	);

endmodule

@@ test/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW_SLOTS = 64;
	localparam int SETTLE_CYCLES = 40;
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PHASE_ITEMS = 170;
	localparam logic [ptrm_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [ptrm_pkg::TS_W-1:0] TS_ALL_ONES = {ptrm_pkg::TS_W{1'b1}};

	typedef struct {
		logic [ptrm_pkg::CNT_W-1:0]  elapsed;
		logic [ptrm_pkg::RATE_W-1:0] rate;
		logic                        sat;
	} tick_report_t;

	logic clk;
	logic arst_n;

	ptrm_item_if   item_ch ();
	ptrm_result_if res_ch ();
	ptrm_cfg_if    cfg_ch ();

	periodic_tick_rate_monitor_top #(
		.WINDOW (WINDOW_SLOTS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	tick_report_t pending_ticks[$];
	int unsigned  mismatches = 0;
	int unsigned  quiet_cycles = 0;
	int unsigned  src_idle_pct = 12;
	int unsigned  sink_idle_pct = 12;
	int unsigned  hold_left = 0;

	// monitor state and its copy of the registers
	logic [ptrm_pkg::CNT_W-1:0]    freq_m = ptrm_pkg::RST_COUNTER_FREQ;
	logic [ptrm_pkg::WINCFG_W-1:0] win_m = ptrm_pkg::RST_WINDOW_LEN;
	logic [ptrm_pkg::CNT_W-1:0]    period_m = ptrm_pkg::RST_TICK_PERIOD;
	bit                            running_m = 1'b0;
	logic [ptrm_pkg::TS_W-1:0]     last_tick_m = '0;
	logic [ptrm_pkg::CNT_W-1:0]    ring_m[WINDOW_SLOTS];
	logic [63:0]                   sum_m = '0;
	int unsigned                   ring_idx_m = 0;

	// stimulus generator state
	logic [ptrm_pkg::TS_W-1:0] gen_ts = '0;
	bit                        gen_running = 1'b0;

	initial begin
		foreach (ring_m[i])
			ring_m[i] = '0;
	end

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		item_ch.valid = 1'b0;
		item_ch.mode = ptrm_pkg::MODE_START;
		item_ch.timestamp = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = ptrm_pkg::REG_COUNTER_FREQ;
		cfg_ch.data = '0;
	end

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic track_item(input logic [ptrm_pkg::MODE_W-1:0] m,
			input logic [ptrm_pkg::TS_W-1:0] ts);
		logic [ptrm_pkg::TS_W-1:0]  elapsed;
		logic [ptrm_pkg::CNT_W-1:0] interval;
		int unsigned                win;
		int unsigned                slot;
		logic [63:0]                num;
		logic [63:0]                quot;
		tick_report_t               rep;
		case (m)
			ptrm_pkg::MODE_START: begin
				last_tick_m = ts;
				running_m = 1'b1;
			end
			ptrm_pkg::MODE_STOP: begin
				running_m = 1'b0;
			end
			ptrm_pkg::MODE_SAMPLE: begin
				elapsed = ts - last_tick_m;
				if (running_m && elapsed >= ptrm_pkg::TS_W'(period_m)) begin
					interval = (elapsed > ptrm_pkg::TS_W'(ptrm_pkg::CNT_MAX)) ?
						ptrm_pkg::CNT_MAX : elapsed[ptrm_pkg::CNT_W-1:0];
					last_tick_m = ts;
					win = 32'(win_m);
					if (win < 1)
						win = 1;
					if (win > WINDOW_SLOTS)
						win = WINDOW_SLOTS;
					slot = (ring_idx_m < win) ? ring_idx_m : 0;
					sum_m = sum_m - 64'(ring_m[slot]) + 64'(interval);
					ring_m[slot] = interval;
					ring_idx_m = (slot + 1 < win) ? slot + 1 : 0;
					rep.elapsed = interval;
					if (sum_m == 0) begin
						rep.rate = ptrm_pkg::RATE_MAX;
						rep.sat = 1'b1;
					end else begin
						num = (64'(win) * 64'(freq_m)) << 8;
						quot = num / sum_m;
						rep.sat = (quot > 64'(ptrm_pkg::RATE_MAX));
						rep.rate = rep.sat ? ptrm_pkg::RATE_MAX : quot[ptrm_pkg::RATE_W-1:0];
					end
					pending_ticks.push_back(rep);
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n && item_ch.valid && item_ch.ready)
			track_item(item_ch.mode, item_ch.timestamp);
	end

	always @(posedge clk) begin
		if (arst_n && cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.index)
				ptrm_pkg::REG_COUNTER_FREQ: freq_m = cfg_ch.data;
				ptrm_pkg::REG_WINDOW_LEN:   win_m = cfg_ch.data[ptrm_pkg::WINCFG_W-1:0];
				ptrm_pkg::REG_TICK_PERIOD:  period_m = cfg_ch.data;
				default: begin
				end
			endcase
		end
	end

	always @(posedge clk) begin : check_results
		tick_report_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_ticks.size() == 0) begin
				flag_mismatch($sformatf("result with nothing pending: elapsed %0h rate %0h",
					res_ch.elapsed_counts, res_ch.rate_q8));
			end else begin
				want = pending_ticks.pop_front();
				if (res_ch.elapsed_counts !== want.elapsed)
					flag_mismatch($sformatf("elapsed_counts %0h, want %0h",
						res_ch.elapsed_counts, want.elapsed));
				if (res_ch.rate_q8 !== want.rate)
					flag_mismatch($sformatf("rate_q8 %0h, want %0h", res_ch.rate_q8, want.rate));
				if (res_ch.rate_saturated !== want.sat)
					flag_mismatch($sformatf("rate_saturated %0b, want %0b",
						res_ch.rate_saturated, want.sat));
			end
		end
	end

	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("periodic_tick_rate_monitor_top regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(input logic [ptrm_pkg::MODE_W-1:0] m,
			input logic [ptrm_pkg::TS_W-1:0] ts);
		@(negedge clk);
		while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.mode <= m;
		item_ch.timestamp <= ts;
		do
			@(posedge clk);
		while (!item_ch.ready);
	endtask

	task automatic write_reg(input logic [ptrm_pkg::CFG_IDX_W-1:0] idx,
			input logic [ptrm_pkg::CFG_DAT_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// drop the item channel, drain every pending tick, let the last command finish
	task automatic settle();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending_ticks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [ptrm_pkg::TS_W-1:0] random_ts();
		return ptrm_pkg::TS_W'({$urandom(), $urandom()});
	endfunction

	function automatic logic [ptrm_pkg::TS_W-1:0] next_step(
			input logic [ptrm_pkg::CNT_W-1:0] p);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (p == 0)
			return ptrm_pkg::TS_W'($urandom_range(0, 3));
		if (pick < 45)
			return ptrm_pkg::TS_W'($urandom_range(0, p / 2));
		if (pick < 90)
			return ptrm_pkg::TS_W'(p) + ptrm_pkg::TS_W'($urandom_range(0, p / 4));
		if (pick < 95)
			return ptrm_pkg::TS_W'(p);
		return random_ts();
	endfunction

	task automatic send_random_item(input logic [ptrm_pkg::CNT_W-1:0] p);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (!gen_running) begin
			if (pick < 80) begin
				gen_ts = (pick < 40) ? random_ts() : gen_ts + next_step(p);
				gen_running = 1'b1;
				send_item(ptrm_pkg::MODE_START, gen_ts);
			end else begin
				send_item(ptrm_pkg::MODE_SAMPLE, random_ts());
			end
		end else if (pick < 4) begin
			gen_ts = random_ts();
			send_item(ptrm_pkg::MODE_START, gen_ts);
		end else if (pick < 7) begin
			gen_running = 1'b0;
			send_item(ptrm_pkg::MODE_STOP, random_ts());
		end else if (pick < 9) begin
			send_item(MODE_UNUSED, random_ts());
		end else if (pick < 11) begin
			send_item(ptrm_pkg::MODE_SAMPLE, random_ts());
		end else begin
			gen_ts = gen_ts + next_step(p);
			send_item(ptrm_pkg::MODE_SAMPLE, gen_ts);
		end
	endtask

	task automatic run_phase(input logic [ptrm_pkg::CNT_W-1:0] freq,
			input logic [ptrm_pkg::CFG_DAT_W-1:0] win,
			input logic [ptrm_pkg::CNT_W-1:0] period, input int unsigned n);
		settle();
		write_reg(ptrm_pkg::REG_COUNTER_FREQ, freq);
		write_reg(ptrm_pkg::REG_WINDOW_LEN, win);
		write_reg(ptrm_pkg::REG_TICK_PERIOD, period);
		gen_running = 1'b0;
		repeat (n) send_random_item(period);
	endtask

	task automatic test_reset_values();
		send_item(ptrm_pkg::MODE_START, '0);
		send_item(ptrm_pkg::MODE_SAMPLE, ptrm_pkg::TS_W'(ptrm_pkg::RST_TICK_PERIOD - 1));
		send_item(MODE_UNUSED, TS_ALL_ONES);
		send_item(ptrm_pkg::MODE_SAMPLE, ptrm_pkg::TS_W'(ptrm_pkg::RST_TICK_PERIOD));
		send_item(ptrm_pkg::MODE_STOP, TS_ALL_ONES);
	endtask

	task automatic test_zero_sum();
		settle();
		write_reg(ptrm_pkg::REG_TICK_PERIOD, '0);
		write_reg(ptrm_pkg::REG_WINDOW_LEN, 32'hFFFF_FF80);
		send_item(ptrm_pkg::MODE_START, TS_ALL_ONES);
		send_item(ptrm_pkg::MODE_SAMPLE, TS_ALL_ONES);
		send_item(ptrm_pkg::MODE_SAMPLE, ptrm_pkg::TS_W'(4));
		settle();
		write_reg(ptrm_pkg::REG_COUNTER_FREQ, '0);
		send_item(ptrm_pkg::MODE_SAMPLE, ptrm_pkg::TS_W'(13));
	endtask

	task automatic test_commands();
		logic [ptrm_pkg::TS_W-1:0] base;
		settle();
		write_reg(ptrm_pkg::REG_COUNTER_FREQ, ptrm_pkg::RST_COUNTER_FREQ);
		write_reg(ptrm_pkg::REG_WINDOW_LEN, ptrm_pkg::CFG_DAT_W'(ptrm_pkg::RST_WINDOW_LEN));
		write_reg(ptrm_pkg::REG_TICK_PERIOD, 32'd1000);
		base = 48'h8000_0000_0000;
		send_item(ptrm_pkg::MODE_STOP, base);
		send_item(ptrm_pkg::MODE_SAMPLE, base + 48'd5000);
		send_item(ptrm_pkg::MODE_START, base);
		send_item(ptrm_pkg::MODE_START, base + 48'd500);
		send_item(ptrm_pkg::MODE_SAMPLE, base + 48'd1200);
		send_item(ptrm_pkg::MODE_SAMPLE, base + 48'd1500);
		send_item(ptrm_pkg::MODE_START, TS_ALL_ONES - 48'd299);
		send_item(ptrm_pkg::MODE_SAMPLE, 48'd800);
		send_item(MODE_UNUSED, 48'd800 + (48'd1 << 40));
		send_item(ptrm_pkg::MODE_SAMPLE, 48'd800 + (48'd1 << 40));
		send_item(ptrm_pkg::MODE_SAMPLE, 48'hAAAA_AAAA_AAAA);
		send_item(ptrm_pkg::MODE_SAMPLE, 48'h5555_5555_5555);
		send_item(ptrm_pkg::MODE_STOP, 48'h5555_5555_5555);
	endtask

	task automatic test_random_configs();
		run_phase(ptrm_pkg::RST_COUNTER_FREQ, 32'd60, ptrm_pkg::RST_TICK_PERIOD, PHASE_ITEMS);
		run_phase(32'd1, 32'd1, 32'd1, PHASE_ITEMS);
		run_phase(ptrm_pkg::CNT_MAX, 32'd64, ptrm_pkg::CNT_MAX, PHASE_ITEMS);
		run_phase(32'd48000, 32'd127, 32'd1000, PHASE_ITEMS);
		run_phase(32'd1000000, 32'd0, 32'd0, PHASE_ITEMS);
		run_phase(32'd0, 32'd7, 32'd500, PHASE_ITEMS);
	endtask

	task automatic test_no_idle();
		src_idle_pct = 0;
		sink_idle_pct = 0;
		run_phase(32'd25000000, 32'd17, 32'd1 << 20, 150);
		src_idle_pct = 12;
		sink_idle_pct = 12;
	endtask

	task automatic test_backpressure();
		settle();
		write_reg(ptrm_pkg::REG_COUNTER_FREQ, ptrm_pkg::RST_COUNTER_FREQ);
		write_reg(ptrm_pkg::REG_WINDOW_LEN, 32'd8);
		write_reg(ptrm_pkg::REG_TICK_PERIOD, '0);
		hold_left = HOLD_OFF_CYCLES;
		gen_ts = random_ts();
		send_item(ptrm_pkg::MODE_START, gen_ts);
		repeat (40) begin
			gen_ts = gen_ts + ptrm_pkg::TS_W'($urandom_range(0, 50));
			send_item(ptrm_pkg::MODE_SAMPLE, gen_ts);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_zero_sum();
		test_commands();
		test_random_configs();
		test_no_idle();
		test_backpressure();
		settle();
		if (mismatches == 0)
			$display("periodic_tick_rate_monitor_top regression: pass");
		else
			$display("periodic_tick_rate_monitor_top regression: fail");
		$finish;
	end

endmodule
